// ----- rtl/sle_pkg.sv -----
// shared types and constants for the sorted list engine
`default_nettype none

package sle_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned VALUE_W       = 32;
   localparam int unsigned COUNT_OUT_W   = 5;

   typedef enum logic [1:0] {
      CMD_INSERT_ORDERED = 2'd0,
      CMD_INSERT_FRONT   = 2'd1,
      CMD_REMOVE_KEY     = 2'd2,
      CMD_REMOVE_FRONT   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type                     cmd;
      logic signed [VALUE_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic signed [VALUE_W-1:0]   result_value;
      logic [COUNT_OUT_W-1:0]      entry_count;
   } rsp_type;

   typedef struct packed {
      logic exec;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/sle_ctrl.sv -----
// handshake controller for the sorted list engine
`default_nettype none

module sle_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sle_pkg::dp_cmd_type    dp_cmd
);
   import sle_pkg::*;

   typedef enum logic {
      ST_EMPTY,
      ST_HOLD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   assign req_ready   = (state_ff == ST_EMPTY) || rsp_ready;
   assign dp_cmd.exec = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      if (dp_cmd.exec) begin
         state_in = ST_HOLD;
      end else if (rsp_ready) begin
         state_in = ST_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_in == ST_HOLD);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sle_datapath.sv -----
// entry cells with parallel compare, shift network and result register
`default_nettype none

module sle_datapath #(
   parameter int unsigned DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  sle_pkg::dp_cmd_type    dp_cmd,
   input  sle_pkg::req_type       req_payload,
   output sle_pkg::rsp_type       rsp_payload
);
   import sle_pkg::*;

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;

   logic [DEPTH-1:0] hit;
   logic [DEPTH-1:0] first;
   logic [DEPTH-1:0] incl;
   logic [DEPTH-1:0] eq;
   logic [DEPTH-1:0] wr;
   logic             seen;
   logic             found;
   logic             full;
   logic             empty;
   logic             is_insert;
   logic             do_shift;
   logic             do_remove;

   always_comb begin
      full  = (count_ff == CNT_W'(DEPTH));
      empty = (count_ff == '0);
      is_insert = (req_payload.cmd == CMD_INSERT_ORDERED) ||
                  (req_payload.cmd == CMD_INSERT_FRONT);

      // per cell compare
      for (int i = 0; i < DEPTH; i++) begin
         eq[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == req_payload.value);
         unique case (req_payload.cmd)
            CMD_INSERT_ORDERED, CMD_REMOVE_KEY: begin
               hit[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] >= req_payload.value);
            end
            CMD_INSERT_FRONT, CMD_REMOVE_FRONT: begin
               hit[i] = (i == 0);
            end
            default: begin
               hit[i] = 1'b0;
            end
         endcase
      end

      // first hit from the head and everything behind it
      seen = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         first[i] = hit[i] && !seen;
         seen     = seen || hit[i];
         incl[i]  = seen;
      end

      for (int i = 0; i < DEPTH; i++) begin
         wr[i] = seen ? first[i] : (CNT_W'(i) == count_ff);
      end

      found = 1'b0;
      unique case (req_payload.cmd)
         CMD_REMOVE_KEY:   found = |(first & eq);
         CMD_REMOVE_FRONT: found = !empty;
         default:          found = 1'b0;
      endcase

      do_shift  = is_insert && !full;
      do_remove = !is_insert && found;

      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_shift) begin
            if (wr[i]) begin
               entries_in[i] = req_payload.value;
            end else if (incl[i]) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (do_remove && incl[i]) begin
            entries_in[i] = entries_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end

      count_in = count_ff;
      if (do_shift) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_remove) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_in.entry_count  = COUNT_OUT_W'(count_in);
      rsp_in.result_value = '0;
      rsp_in.status       = STATUS_DONE;
      if (is_insert) begin
         if (full) begin
            rsp_in.status = STATUS_FULL;
         end else begin
            rsp_in.result_value = req_payload.value;
         end
      end else if (!found) begin
         rsp_in.status = STATUS_MISS;
      end else if (req_payload.cmd == CMD_REMOVE_FRONT) begin
         rsp_in.result_value = entries_ff[0];
      end else begin
         rsp_in.result_value = req_payload.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (dp_cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         entries_ff <= entries_in;
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/sorted_list_engine_unit.sv -----
// top level of the sorted list engine
// The engine keeps up to DEPTH signed 32-bit values in one register cell per
// entry. Every cell compares its value against the incoming item in parallel,
// so an item can be accepted every cycle while the result channel is not
// stalled; the result register sits between the two channels, so a new item is
// taken in the same cycle the waiting result is taken. The result appears in
// the cycle after the item is accepted. The list is empty after reset.
`default_nettype none

module sorted_list_engine_unit #(
   parameter int unsigned DEPTH = sle_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  sle_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sle_pkg::rsp_type       rsp_payload
);
   import sle_pkg::*;

   dp_cmd_type dp_cmd;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_cmd    (dp_cmd)
   );

   sle_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .dp_cmd      (dp_cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- bench/tb_sorted_list_engine_unit.sv -----
// self-checking testbench for the sorted list engine: directed and random commands
`default_nettype none

module tb_sorted_list_engine_unit;
   import sle_pkg::*;

   localparam int unsigned LIST_DEPTH     = 16;
   localparam int unsigned QUIET_TAIL     = 150;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned RANDOM_ITEMS   = 900;
   localparam int unsigned MAX_PRINTED    = 40;

   typedef struct {
      req_type item;
      bit      drain;
      bit      idle;
   } queued_cmd_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   queued_cmd_type pending_cmds[$];
   rsp_type        expected_rsps[$];

   logic signed [VALUE_W-1:0] list_vals[LIST_DEPTH];
   int unsigned list_fill    = 0;
   int          outstanding  = 0;
   int          mismatches   = 0;
   int          send_gap     = 0;
   int          ready_hold   = 0;
   int          quiet_cycles = 0;
   bit          idle_allowed = 1'b0;

   sorted_list_engine_unit #(.DEPTH(LIST_DEPTH)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      if (mismatches < MAX_PRINTED) begin
         $display("mismatch: %s got %0d expected %0d", what, got, want);
      end
      mismatches++;
   endtask

   // updates the list copy and returns the response the command should give
   function automatic rsp_type apply_command(req_type item);
      rsp_type                   r;
      logic signed [VALUE_W-1:0] key;
      int unsigned               pos;
      int unsigned               i;
      bit                        hit;
      key            = item.value;
      r.status       = STATUS_DONE;
      r.result_value = '0;
      pos            = 0;
      hit            = 1'b0;
      case (item.cmd)
         CMD_INSERT_ORDERED, CMD_INSERT_FRONT: begin
            if (list_fill >= LIST_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               if (item.cmd == CMD_INSERT_ORDERED) begin
                  while (pos < list_fill && list_vals[pos] < key) pos++;
               end
               for (i = list_fill; i > pos; i--) list_vals[i] = list_vals[i-1];
               list_vals[pos] = key;
               list_fill++;
               r.result_value = key;
            end
         end
         CMD_REMOVE_KEY: begin
            while (pos < list_fill && !hit && !(list_vals[pos] > key)) begin
               if (list_vals[pos] == key) hit = 1'b1;
               else pos++;
            end
            if (hit) begin
               r.result_value = list_vals[pos];
               for (i = pos; i + 1 < list_fill; i++) list_vals[i] = list_vals[i+1];
               list_fill--;
            end else begin
               r.status = STATUS_MISS;
            end
         end
         default: begin
            if (list_fill == 0) begin
               r.status = STATUS_MISS;
            end else begin
               r.result_value = list_vals[0];
               for (i = 0; i + 1 < list_fill; i++) list_vals[i] = list_vals[i+1];
               list_fill--;
            end
         end
      endcase
      r.entry_count = list_fill[COUNT_OUT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : sender
      queued_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() == 0 ||
                      (pending_cmds[0].drain && (req_valid || outstanding != 0))) begin
            req_valid <= 1'b0;
         end else begin
            nxt = pending_cmds.pop_front();
            req_payload  <= nxt.item;
            req_valid    <= 1'b1;
            idle_allowed <= nxt.idle && pending_cmds.size() > QUIET_TAIL;
            if (nxt.idle && pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(1, 11);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold--;
         rsp_ready <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
         ready_hold = $urandom_range(0, 10);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      int      taken;
      int      returned;
      taken    = 0;
      returned = 0;
      if (reset) begin
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            returned = 1;
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected item, status", rsp_payload.status, -1);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.status != want.status)
                  report_mismatch("status", rsp_payload.status, want.status);
               if (rsp_payload.result_value != want.result_value)
                  report_mismatch("result_value", $signed(rsp_payload.result_value),
                                  $signed(want.result_value));
               if (rsp_payload.entry_count != want.entry_count)
                  report_mismatch("entry_count", rsp_payload.entry_count, want.entry_count);
            end
         end
         if (req_valid && req_ready) begin
            taken = 1;
            expected_rsps.push_back(apply_command(req_payload));
         end
         outstanding <= outstanding + taken - returned;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[sorted_list_engine_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_cmd(cmd_type c, logic [VALUE_W-1:0] v, bit drain, bit idle);
      queued_cmd_type q;
      q.item.cmd   = c;
      q.item.value = v;
      q.drain      = drain;
      q.idle       = idle;
      pending_cmds.push_back(q);
   endtask

   initial begin
      logic [VALUE_W-1:0] key_pool[8];
      logic [VALUE_W-1:0] v;
      int unsigned        generated;
      int unsigned        phase_len;
      int unsigned        insert_weight;
      int unsigned        roll;
      int unsigned        k;
      bit                 idle_phase;
      bit                 drain_next;

      // empty list, extremes, duplicates, out-of-order head
      queue_cmd(CMD_REMOVE_FRONT,   $urandom, 1'b0, 1'b0);
      queue_cmd(CMD_REMOVE_KEY,     32'h0000_0000, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_ORDERED, 32'h8000_0000, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_ORDERED, 32'h7fff_ffff, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_ORDERED, 32'h0000_0000, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_ORDERED, 32'hffff_ffff, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_ORDERED, 32'h0000_0000, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_FRONT,   32'h0000_0005, 1'b0, 1'b0);
      queue_cmd(CMD_REMOVE_KEY,     32'h0000_0005, 1'b0, 1'b0);
      queue_cmd(CMD_REMOVE_KEY,     32'h0000_0003, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_FRONT,   32'h0000_0007, 1'b0, 1'b0);
      queue_cmd(CMD_REMOVE_KEY,     32'h0000_0000, 1'b0, 1'b0);
      queue_cmd(CMD_REMOVE_KEY,     32'h0000_0007, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_ORDERED, 32'h0000_0001, 1'b0, 1'b0);
      queue_cmd(CMD_REMOVE_FRONT,   32'h0000_0000, 1'b0, 1'b0);
      queue_cmd(CMD_REMOVE_KEY,     32'h7fff_ffff, 1'b0, 1'b0);
      for (k = 0; k < 12; k++) queue_cmd(CMD_INSERT_FRONT, $urandom, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_ORDERED, $urandom, 1'b0, 1'b0);
      queue_cmd(CMD_INSERT_FRONT,   $urandom, 1'b0, 1'b0);

      generated  = 0;
      drain_next = 1'b1;
      while (generated < RANDOM_ITEMS) begin
         phase_len  = $urandom_range(40, 120);
         if (phase_len > RANDOM_ITEMS - generated) phase_len = RANDOM_ITEMS - generated;
         idle_phase = $urandom_range(0, 3) != 0;
         case ($urandom_range(0, 2))
            0: insert_weight = 25;
            1: insert_weight = 50;
            default: insert_weight = 75;
         endcase
         key_pool[0] = 32'h8000_0000;
         key_pool[1] = 32'h7fff_ffff;
         key_pool[2] = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
         key_pool[3] = $urandom_range(0, 20) - 10;
         for (k = 4; k < 8; k++) key_pool[k] = $urandom;
         for (k = 0; k < phase_len; k++) begin
            v    = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : $urandom;
            roll = $urandom_range(0, 99);
            if (roll < insert_weight) begin
               if ($urandom_range(0, 3) == 0)
                  queue_cmd(CMD_INSERT_FRONT, v, drain_next, idle_phase);
               else
                  queue_cmd(CMD_INSERT_ORDERED, v, drain_next, idle_phase);
            end else if ($urandom_range(0, 9) < 7) begin
               queue_cmd(CMD_REMOVE_KEY, v, drain_next, idle_phase);
            end else begin
               queue_cmd(CMD_REMOVE_FRONT, v, drain_next, idle_phase);
            end
            drain_next = 1'b0;
         end
         generated += phase_len;
         drain_next = $urandom_range(0, 2) == 0;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_valid || outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch("items left waiting", 0, expected_rsps.size());

      if (mismatches == 0) begin
         $display("[sorted_list_engine_unit] OK");
      end else begin
         $display("[sorted_list_engine_unit] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
